/* hw/rtl/cte_pkg.sv */
// Shared types, constants and tables for the calendar-to-epoch-seconds pipeline.
// Used by cte_fold, cte_days, cte_scale and the top level; no dependencies.
`default_nettype none

package cte_pkg;

  // Field widths of the input request and the result
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 9;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned EpochW  = 39;

  // Packed stream widths (whole bytes)
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  // Adjusted calendar year, wide enough for every input bit pattern
  localparam int unsigned YrW   = 15;
  // Signed day count relative to the epoch
  localparam int unsigned DaysW = 24;
  // Seconds within a day from hour, minute and second
  localparam int unsigned HmsW  = 17;

  localparam logic [YrW-1:0]   YearBase    = 15'd1900;
  // Days from year 1 to 1970-01-01
  localparam logic [DaysW-1:0] DaysTo1970  = 24'd719162;
  localparam logic [17:0]      SecsPerDay  = 18'd86400;
  // ceil(2^20 / 100): exact quotient by 100 for magnitudes below 2^14
  localparam logic [13:0]      Recip100    = 14'd10486;
  localparam int unsigned      Recip100Sh  = 20;
  // ceil(2^11 / 12): exact quotient by 12 for values below 268
  localparam logic [7:0]       Recip12     = 8'd171;
  localparam int unsigned      Recip12Sh   = 11;

  // Folded month and adjusted year
  typedef struct packed {
    logic [YrW-1:0]     year;
    logic [3:0]         month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } fold_t;

  // Quotients for the leap-day count and the leap test
  typedef struct packed {
    logic [YrW-1:0]     prev_year;
    logic               prev_neg;
    logic [11:0]        prev_div4;
    logic [6:0]         prev_div100;
    logic [4:0]         prev_div400;
    logic [13:0]        year_mag;
    logic [6:0]         year_div100;
    logic [1:0]         year_lo;
    logic [3:0]         month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } quot_t;

  // Day count since the epoch plus time of day
  typedef struct packed {
    logic [DaysW-1:0]   days;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } days_t;

  // Days before the first of the month
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = leap ? 9'd60  : 9'd59;
      4'd3:    d = leap ? 9'd91  : 9'd90;
      4'd4:    d = leap ? 9'd121 : 9'd120;
      4'd5:    d = leap ? 9'd152 : 9'd151;
      4'd6:    d = leap ? 9'd182 : 9'd181;
      4'd7:    d = leap ? 9'd213 : 9'd212;
      4'd8:    d = leap ? 9'd244 : 9'd243;
      4'd9:    d = leap ? 9'd274 : 9'd273;
      4'd10:   d = leap ? 9'd305 : 9'd304;
      4'd11:   d = leap ? 9'd335 : 9'd334;
      default: d = leap ? 9'd335 : 9'd334;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cte_fold.sv */
// Stage 1: fold an out-of-range month into the year and add the 1900 offset.
// Depends on cte_pkg.
`default_nettype none

module cte_fold (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [cte_pkg::YearW-1:0]    year_i,
  input  wire logic [cte_pkg::MonthW-1:0]   month_i,
  input  wire logic [cte_pkg::DayW-1:0]     day_i,
  input  wire logic [cte_pkg::HourW-1:0]    hour_i,
  input  wire logic [cte_pkg::MinuteW-1:0]  minute_i,
  input  wire logic [cte_pkg::SecondW-1:0]  second_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output cte_pkg::fold_t                    out_o
);
  import cte_pkg::*;

  logic        valid_q;
  logic        en;
  fold_t       data_d, data_q;
  logic        mon_pos, mon_neg;
  logic [9:0]  mon_x, div_arg;
  logic [15:0] prod;
  logic [4:0]  quot;
  logic [9:0]  mon_adj;
  logic [YrW-1:0] year_base;

  // Quotient by 12 through a reciprocal multiply
  always_comb begin
    mon_x   = {month_i[MonthW-1], month_i};
    mon_neg = month_i[MonthW-1];
    mon_pos = !month_i[MonthW-1] && (month_i > 9'd11);
    div_arg = mon_neg ? (10'd11 - mon_x) : mon_x;
    prod    = 16'(div_arg) * 16'(Recip12);
    quot    = prod[Recip12Sh+4:Recip12Sh];
  end

  // Fold month into 0..11 and move whole years
  always_comb begin
    year_base = {year_i[YearW-1], year_i} + YearBase;
    if (mon_pos) begin
      mon_adj = mon_x - 10'(quot) * 10'd12;
    end else if (mon_neg) begin
      mon_adj = mon_x + 10'(quot) * 10'd12;
    end else begin
      mon_adj = mon_x;
    end
    data_d.month  = mon_adj[3:0];
    data_d.year   = mon_pos ? year_base + YrW'(quot)
                  : mon_neg ? year_base - YrW'(quot) : year_base;
    data_d.day    = day_i;
    data_d.hour   = hour_i;
    data_d.minute = minute_i;
    data_d.second = second_i;
  end

  // Advance when the stage is empty or its request moves on
  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

/* hw/rtl/cte_days.sv */
// Stages 2 and 3: leap-day quotients, leap test and day count since the epoch.
// Depends on cte_pkg.
`default_nettype none

module cte_days (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire cte_pkg::fold_t  in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output cte_pkg::days_t       out_o
);
  import cte_pkg::*;

  logic           a_valid_q, b_valid_q;
  logic           a_en, b_en;
  quot_t          a_d, a_q;
  days_t          b_d, b_q;
  logic [YrW-1:0] prev;
  logic [13:0]    prev_mag, year_mag;
  logic [27:0]    prod_p100, prod_p400, prod_y100;

  // Stage 2: magnitudes and quotients by 4, 100 and 400 (truncating)
  always_comb begin
    prev      = in_i.year - YrW'(1);
    prev_mag  = prev[YrW-1]      ? 14'(-prev)      : prev[13:0];
    year_mag  = in_i.year[YrW-1] ? 14'(-in_i.year) : in_i.year[13:0];
    prod_p100 = 28'(prev_mag) * 28'(Recip100);
    prod_p400 = 28'(prev_mag[13:2]) * 28'(Recip100);
    prod_y100 = 28'(year_mag) * 28'(Recip100);

    a_d.prev_year   = prev;
    a_d.prev_neg    = prev[YrW-1];
    a_d.prev_div4   = prev_mag[13:2];
    a_d.prev_div100 = prod_p100[Recip100Sh+6:Recip100Sh];
    a_d.prev_div400 = prod_p400[Recip100Sh+4:Recip100Sh];
    a_d.year_mag    = year_mag;
    a_d.year_div100 = prod_y100[Recip100Sh+6:Recip100Sh];
    a_d.year_lo     = in_i.year[1:0];
    a_d.month       = in_i.month;
    a_d.day         = in_i.day;
    a_d.hour        = in_i.hour;
    a_d.minute      = in_i.minute;
    a_d.second      = in_i.second;
  end

  // Stage 3: leap test and signed day count
  logic                    leap;
  logic [13:0]             year_rem;
  logic signed [DaysW-1:0] p_x, d4, d100, d400, cum_x, day_x, days;

  always_comb begin
    year_rem = a_q.year_mag - 14'(a_q.year_div100) * 14'd100;
    leap     = (year_rem == 14'd0) ? (a_q.year_div100[1:0] == 2'd0)
                                   : (a_q.year_lo == 2'd0);
    p_x   = {{(DaysW-YrW){a_q.prev_year[YrW-1]}}, a_q.prev_year};
    d4    = a_q.prev_neg ? -$signed({12'd0, a_q.prev_div4})  : $signed({12'd0, a_q.prev_div4});
    d100  = a_q.prev_neg ? -$signed({17'd0, a_q.prev_div100})
                         :  $signed({17'd0, a_q.prev_div100});
    d400  = a_q.prev_neg ? -$signed({19'd0, a_q.prev_div400})
                         :  $signed({19'd0, a_q.prev_div400});
    cum_x = $signed({15'd0, cum_days(leap, a_q.month)});
    day_x = $signed({19'd0, a_q.day});
    days  = p_x * 24'sd365 + d400 - d100 + d4 - $signed(DaysTo1970) + cum_x + day_x
          - 24'sd1;

    b_d.days   = days;
    b_d.hour   = a_q.hour;
    b_d.minute = a_q.minute;
    b_d.second = a_q.second;
  end

  // Per-stage handshake: fill bubbles, hold on stall
  assign b_en       = !b_valid_q || out_ready_i;
  assign a_en       = !a_valid_q || b_en;
  assign in_ready_o = a_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_q <= in_valid_i;
      end
      if (b_en) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && in_valid_i) begin
      a_q <= a_d;
    end
    if (b_en && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_o       = b_q;

endmodule

`default_nettype wire

/* hw/rtl/cte_scale.sv */
// Stages 4 and 5: scale days to seconds, add the time of day, hold the result.
// Depends on cte_pkg.
`default_nettype none

module cte_scale (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire cte_pkg::days_t             in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [cte_pkg::EpochW-1:0]      epoch_o
);
  import cte_pkg::*;

  logic                   c_valid_q, d_valid_q;
  logic                   c_en, d_en;
  logic signed [41:0]     prod;
  logic [HmsW-1:0]        hms;
  logic [EpochW-1:0]      sec_d, sec_q;
  logic [HmsW-1:0]        hms_q;
  logic [EpochW-1:0]      epoch_d, epoch_q;

  // Stage 4: day count times seconds per day, time of day in seconds
  always_comb begin
    prod  = $signed({{(42-DaysW){in_i.days[DaysW-1]}}, in_i.days})
          * $signed({24'd0, SecsPerDay});
    sec_d = prod[EpochW-1:0];
    hms   = HmsW'(in_i.hour) * HmsW'(3600) + HmsW'(in_i.minute) * HmsW'(60)
          + HmsW'(in_i.second);
  end

  // Stage 5: final sum, wraps within the result width
  assign epoch_d = sec_q + EpochW'(hms_q);

  assign d_en       = !d_valid_q || out_ready_i;
  assign c_en       = !c_valid_q || d_en;
  assign in_ready_o = c_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_en) begin
        c_valid_q <= in_valid_i;
      end
      if (d_en) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_en && in_valid_i) begin
      sec_q <= sec_d;
      hms_q <= hms;
    end
    if (d_en && c_valid_q) begin
      epoch_q <= epoch_d;
    end
  end

  assign out_valid_o = d_valid_q;
  assign epoch_o     = epoch_q;

endmodule

`default_nettype wire

/* hw/rtl/calendar_to_epoch_seconds.sv */
// Top level: UTC calendar date and time to signed seconds since 1970-01-01.
// Depends on cte_pkg, cte_fold, cte_days and cte_scale.
//
//   Channel   Dir  Handshake                    Payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata: year, month, day, h, m, s
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: epoch_seconds
//
// Five register stages: month fold, quotients, day count, day scaling, sum.
// One request per cycle is sustained while m_axis_tready stays high. Every
// stage advances when empty or when its successor takes its request, so a
// stall on m_axis holds all data and bubbles still fill.
// Reset clears the valid bits only; the data registers are not reset.
`default_nettype none

module calendar_to_epoch_seconds (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [13:0] year_since_1900, [22:14] month_raw, [27:23] day_of_month,
  // [32:28] hour, [38:33] minute, [44:39] second, [47:45] zero
  input  wire logic [cte_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [38:0] epoch_seconds, [39] zero
  output logic [cte_pkg::OutDataW-1:0]       m_axis_tdata
);
  import cte_pkg::*;

  logic              fold_valid, fold_ready;
  fold_t             fold_data;
  logic              days_valid, days_ready;
  days_t             days_data;
  logic [EpochW-1:0] epoch;

  // Month fold and year offset
  cte_fold u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .year_i      (s_axis_tdata[13:0]),
    .month_i     (s_axis_tdata[22:14]),
    .day_i       (s_axis_tdata[27:23]),
    .hour_i      (s_axis_tdata[32:28]),
    .minute_i    (s_axis_tdata[38:33]),
    .second_i    (s_axis_tdata[44:39]),
    .out_valid_o (fold_valid),
    .out_ready_i (fold_ready),
    .out_o       (fold_data)
  );

  // Day count since the epoch
  cte_days u_days (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fold_valid),
    .in_ready_o  (fold_ready),
    .in_i        (fold_data),
    .out_valid_o (days_valid),
    .out_ready_i (days_ready),
    .out_o       (days_data)
  );

  // Seconds and output register
  cte_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (days_valid),
    .in_ready_o  (days_ready),
    .in_i        (days_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .epoch_o     (epoch)
  );

  assign m_axis_tdata = {{(OutDataW-EpochW){1'b0}}, epoch};

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking bench for calendar_to_epoch_seconds: directed dates, then random bursts.
// Predicts each result in a scoreboard class; needs cte_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;
  import cte_pkg::*;

  // Bit offsets of the request fields inside s_axis_tdata
  localparam int unsigned OffMonth  = YearW;
  localparam int unsigned OffDay    = OffMonth + MonthW;
  localparam int unsigned OffHour   = OffDay + DayW;
  localparam int unsigned OffMinute = OffHour + HourW;
  localparam int unsigned OffSecond = OffMinute + MinuteW;

  localparam int LongHold   = 300;
  localparam int StallLimit = 4000;
  localparam int RandPhase  = 230;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [13:0] year_since_1900, [22:14] month_raw, [27:23] day_of_month,
  // [32:28] hour, [38:33] minute, [44:39] second, [47:45] zero
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [38:0] epoch_seconds, [39] zero
  logic [OutDataW-1:0] m_axis_tdata;

  bit hold_req;
  int idle_cycles;

  calendar_to_epoch_seconds dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Holds expected epoch seconds in request order and checks each result
  class epoch_scoreboard;
    logic [EpochW-1:0] pending_epochs[$];
    int errors;
    int requests;
    int results;

    function new();
      errors   = 0;
      requests = 0;
      results  = 0;
    endfunction

    // Days from 0001-01-01 to January 1st of year y (truncating division)
    function longint days_before_year(longint y);
      longint p;
      p = y - 1;
      return 365 * p + p / 400 - p / 100 + p / 4;
    endfunction

    function logic [EpochW-1:0] predict_epoch(logic [InDataW-1:0] req);
      int     month_start[12];
      longint yr, mon, back, days, total;
      bit     leap;
      month_start = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      yr  = longint'($signed(req[YearW-1:0])) + 1900;
      mon = longint'($signed(req[OffMonth +: MonthW]));
      // fold the month into the year, flooring for negative months
      if (mon > 11) begin
        yr  = yr + mon / 12;
        mon = mon % 12;
      end else if (mon < 0) begin
        back = (11 - mon) / 12;
        yr   = yr - back;
        mon  = mon + 12 * back;
      end
      leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
      days = days_before_year(yr) - days_before_year(1970) + month_start[mon]
           + ((leap && mon >= 2) ? 1 : 0) + longint'(req[OffDay +: DayW]) - 1;
      total = days * 86400 + 3600 * longint'(req[OffHour +: HourW])
            + 60 * longint'(req[OffMinute +: MinuteW]) + longint'(req[OffSecond +: SecondW]);
      return total[EpochW-1:0];
    endfunction

    function void note_request(logic [InDataW-1:0] req);
      pending_epochs.push_back(predict_epoch(req));
      requests++;
    endfunction

    function void check_result(logic [OutDataW-1:0] res);
      logic [EpochW-1:0] want;
      if (pending_epochs.size() == 0) begin
        $error("epoch_seconds: result %0d with no request outstanding",
               $signed(res[EpochW-1:0]));
        errors++;
        return;
      end
      want = pending_epochs.pop_front();
      results++;
      if (res[EpochW-1:0] !== want) begin
        $error("epoch_seconds mismatch: expected %0d, actual %0d",
               $signed(want), $signed(res[EpochW-1:0]));
        errors++;
      end
    endfunction
  endclass

  epoch_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  // Record accepted requests, check results, watch for a hung pipeline
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $error("no handshake for %0d cycles, %0d results outstanding",
             StallLimit, sb.pending_epochs.size());
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall in random patterns, plus one long hold on request
  initial begin
    int mode;
    int span;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_req) begin
          m_axis_tready <= 1'b0;
          repeat (LongHold) @(negedge clk_i);
          hold_req = 1'b0;
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(0, 1);
          2:       m_axis_tready <= ($urandom_range(0, 4) != 0);
          default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  function automatic logic [InDataW-1:0] pack_request(int yr, int mon, int day, int hr,
                                                      int mi, int se);
    logic [InDataW-1:0] req;
    req = '0;
    req[YearW-1:0]              = yr[YearW-1:0];
    req[OffMonth +: MonthW]     = mon[MonthW-1:0];
    req[OffDay +: DayW]         = day[DayW-1:0];
    req[OffHour +: HourW]       = hr[HourW-1:0];
    req[OffMinute +: MinuteW]   = mi[MinuteW-1:0];
    req[OffSecond +: SecondW]   = se[SecondW-1:0];
    return req;
  endfunction

  // Mostly legal dates, some near century boundaries, some raw bit patterns
  function automatic logic [InDataW-1:0] random_request();
    int yr, mon, day, hr, mi, se, pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) yr = int'($urandom_range(0, 9978)) - 1889;
    else if (pick < 8) yr = int'($urandom_range(0, 99)) * 100 - 1900 + int'($urandom_range(0, 8)) - 4;
    else yr = $urandom_range(0, 16383);
    pick = $urandom_range(0, 9);
    if (pick < 7) mon = $urandom_range(0, 11);
    else if (pick < 9) mon = int'($urandom_range(0, 251)) - 120;
    else mon = $urandom_range(0, 511);
    day = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 31) : $urandom_range(0, 31);
    hr  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 23) : $urandom_range(0, 31);
    mi  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(0, 63);
    se  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 60) : $urandom_range(0, 63);
    return pack_request(yr, mon, day, hr, mi, se);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(input logic [InDataW-1:0] req);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending_epochs.size() != 0) @(negedge clk_i);
  endtask

  // Send random requests in bursts separated by random gaps
  task automatic random_bursts(input int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && count > 0) begin
        send_request(random_request());
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    hold_req      = 1'b0;
    idle_cycles   = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: range ends, epoch neighbors, leap rules, month folding
    send_request(pack_request(-1889, 0, 1, 0, 0, 0));
    send_request(pack_request(8099, 11, 31, 23, 59, 60));
    send_request(pack_request(70, 0, 1, 0, 0, 0));
    send_request(pack_request(69, 11, 31, 23, 59, 59));
    send_request(pack_request(100, 1, 29, 12, 0, 0));
    send_request(pack_request(0, 1, 29, 0, 0, 0));
    send_request(pack_request(0, 2, 1, 0, 0, 0));
    send_request(pack_request(104, 2, 1, 0, 0, 0));
    send_request(pack_request(200, 2, 1, 0, 0, 0));
    send_request(pack_request(70, 12, 1, 0, 0, 0));
    send_request(pack_request(70, -1, 1, 0, 0, 0));
    send_request(pack_request(70, -12, 1, 0, 0, 0));
    send_request(pack_request(70, -13, 1, 0, 0, 0));
    send_request(pack_request(70, 131, 15, 6, 30, 30));
    send_request(pack_request(70, -120, 15, 6, 30, 30));
    send_request(pack_request(70, 255, 1, 0, 0, 0));
    send_request(pack_request(70, -256, 1, 0, 0, 0));
    send_request(pack_request(8191, 255, 31, 31, 63, 63));
    send_request(pack_request(-8192, -256, 0, 0, 0, 0));
    send_request(pack_request(-1900, 0, 1, 0, 0, 0));
    send_request(pack_request(-1901, 0, 1, 0, 0, 0));
    send_request(pack_request(-2000, 5, 15, 8, 20, 10));
    send_request(pack_request(70, 0, 0, 31, 63, 63));
    send_request(pack_request(124, 1, 29, 12, 30, 45));
    idle_sender(3);

    random_bursts(RandPhase);

    // Hold the result side off while requests keep coming, filling the pipeline
    hold_req = 1'b1;
    repeat (40) send_request(random_request());
    random_bursts(RandPhase);

    // Pause until every outstanding result has come back
    idle_sender(1);
    wait_drained();
    random_bursts(RandPhase);

    idle_sender(1);
    wait_drained();
    repeat (12) @(negedge clk_i);

    if (sb.pending_epochs.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_epochs.size());
      sb.errors++;
    end
    $display("summary: %0d requests, %0d results checked; range ends, leap rules,",
             sb.requests, sb.results);
    $display("summary: folded and raw months, unchecked fields, long backpressure");
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
